/* src/tdi_pkg.sv */
// shared types and constants for the 2d table interpolation core
package tdi_pkg;
    localparam int MaxXPoints = 16;
    localparam int MaxYPoints = 16;
    localparam int XIdxW = $clog2(MaxXPoints);
    localparam int YIdxW = $clog2(MaxYPoints);
    localparam int ZAddrW = XIdxW + YIdxW;
    localparam int CountW = 5;

    typedef enum logic [1:0] {
        CMD_WRITE_X = 2'd0,
        CMD_WRITE_Y = 2'd1,
        CMD_WRITE_Z = 2'd2,
        CMD_LOOKUP  = 2'd3
    } cmd_t;

    localparam logic CFG_X_POINTS = 1'b0;
    localparam logic CFG_Y_POINTS = 1'b1;

    // operands for one interpolation step
    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] q;
        logic signed [31:0] b;
        logic signed [31:0] va;
        logic signed [31:0] vb;
    } step_args_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               zero_span;
        logic               saturated;
    } step_res_t;
endpackage

/* src/tdi_ram.sv */
// generic single-port-write ram with registered read
module tdi_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/tdi_interp_unit.sv */
// one interpolation step: multiply, restoring divide, add and saturate
module tdi_interp_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tdi_pkg::step_args_t args,
    output logic                done,
    output tdi_pkg::step_res_t  res
);
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_SUM, S_DONE} state_t;

    state_t             state_reg, state_next;
    logic [32:0]        mq_reg, mv_reg, md_reg;
    logic               neg_reg, zero_reg;
    logic signed [31:0] va_reg;
    logic [32:0]        rem_reg;
    logic [65:0]        quo_reg;
    logic [6:0]         cnt_reg;
    logic               done_reg;
    tdi_pkg::step_res_t res_reg;

    logic signed [32:0] dq, dv, dd;
    logic [33:0]        rem_sh;
    logic [34:0]        trial;
    logic signed [34:0] sum;
    logic               big;

    assign dq = 33'(args.q) - 33'(args.a);
    assign dv = 33'(args.vb) - 33'(args.va);
    assign dd = 33'(args.b) - 33'(args.a);

    // shift one quotient bit per cycle
    assign rem_sh = {rem_reg, quo_reg[65]};
    assign trial  = {1'b0, rem_sh} - {2'b0, md_reg};
    assign big    = |quo_reg[65:33] && quo_reg[65:0] > 66'h1_0000_0000;
    assign sum    = neg_reg ? 35'(va_reg) - 35'(quo_reg[33:0])
                            : 35'(va_reg) + 35'(quo_reg[33:0]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_MUL;
            S_MUL:  state_next = zero_reg ? S_DONE : S_DIV;
            S_DIV:  if (cnt_reg == 7'd65) state_next = S_SUM;
            S_SUM:  state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mq_reg   <= dq[32] ? 33'(-dq) : 33'(dq);
                        mv_reg   <= dv[32] ? 33'(-dv) : 33'(dv);
                        md_reg   <= dd[32] ? 33'(-dd) : 33'(dd);
                        neg_reg  <= (dq[32] ^ dv[32]) ^ dd[32];
                        zero_reg <= (dd == '0);
                        va_reg   <= args.va;
                    end
                end
                S_MUL:
                begin
                    // product loads the dividend shifter
                    quo_reg <= 66'(mq_reg) * 66'(mv_reg);
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    if (zero_reg)
                    begin
                        res_reg <= '{value: va_reg, zero_span: 1'b1, saturated: 1'b0};
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (!trial[34])
                    begin
                        rem_reg <= trial[32:0];
                        quo_reg <= {quo_reg[64:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[32:0];
                        quo_reg <= {quo_reg[64:0], 1'b0};
                    end
                end
                S_SUM:
                begin
                    res_reg.zero_span <= 1'b0;
                    if (big)
                    begin
                        res_reg.value     <= neg_reg ? 32'sh8000_0000 : 32'sh7fff_ffff;
                        res_reg.saturated <= 1'b1;
                    end
                    else if (sum > 35'sh0_7fff_ffff)
                    begin
                        res_reg.value     <= 32'sh7fff_ffff;
                        res_reg.saturated <= 1'b1;
                    end
                    else if (sum < -35'sh0_8000_0000)
                    begin
                        res_reg.value     <= 32'sh8000_0000;
                        res_reg.saturated <= 1'b1;
                    end
                    else
                    begin
                        res_reg.value     <= sum[31:0];
                        res_reg.saturated <= 1'b0;
                    end
                end
                S_DONE: done_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg <= 7'd65) else $error("divide overran");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == S_IDLE) else $error("start while busy");
endmodule

/* src/two_d_table_interpolation_core.sv */
// 2d map store, breakpoint search sequencer and output register
//
// channel   dir  payload
// s_axis    in   command, row_index, column_index, write_value, query_x, query_y
// m_axis    out  interpolated, zero_span, saturated
// cfg       in   index 0 x_points_used, 1 y_points_used
//
// a write item goes through S_WRITE; a lookup searches the breakpoints of each
// axis, reads the four corner values and their breakpoints, then runs 3 steps,
// each a multiply and the 66-iteration restoring divider in the shared step
// unit (a zero span step skips the divider).
// reset clears control and the point counts to 16; tables are unset.
// s_axis_tready is low from acceptance until the write is done or the result leaves m_axis.
module two_d_table_interpolation_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] command, [5:2] row_index, [9:6] column_index, [41:10] write_value,
    // [73:42] query_x, [105:74] query_y, rest zero
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] interpolated, [32] zero_span, [33] saturated, rest zero
    output logic [39:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [4:0]   cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_SX, S_SX_CHK, S_SY, S_SY_CHK, S_RD, S_RD_WAIT,
        S_STEP, S_STEP_WAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic [tdi_pkg::CountW-1:0] nx_cfg_reg, ny_cfg_reg;
    logic [1:0]   cmd_reg;
    logic [3:0]   row_reg, col_reg;
    logic signed [31:0] wv_reg, qx_reg, qy_reg;
    logic [tdi_pkg::XIdxW:0] xi_reg;
    logic [tdi_pkg::YIdxW:0] yi_reg;
    logic [tdi_pkg::XIdxW-1:0] xl_reg, xh_reg;
    logic [tdi_pkg::YIdxW-1:0] yl_reg, yh_reg;
    logic [1:0]   ph_reg;
    logic signed [31:0] xa_reg, xb_reg, ya_reg, yb_reg;
    logic signed [31:0] z0_reg, z1_reg, z2_reg, z3_reg, lo_reg, hi_reg;
    logic         zs_reg, sat_reg, start_reg, ov_reg;
    logic [39:0]  od_reg;

    logic [tdi_pkg::XIdxW:0] nx;
    logic [tdi_pkg::YIdxW:0] ny;
    logic [tdi_pkg::XIdxW-1:0] xr_addr;
    logic [tdi_pkg::YIdxW-1:0] yr_addr;
    logic [tdi_pkg::ZAddrW-1:0] zr_addr;
    logic [31:0]  xr_data, yr_data, zr_data;
    logic         x_we, y_we, z_we;
    tdi_pkg::step_args_t args;
    tdi_pkg::step_res_t  sres;
    logic         sdone;

    // clamp point counts
    assign nx = (nx_cfg_reg < 5'd2) ? 5'd2 : (nx_cfg_reg > 5'(tdi_pkg::MaxXPoints))
              ? 5'(tdi_pkg::MaxXPoints) : nx_cfg_reg;
    assign ny = (ny_cfg_reg < 5'd2) ? 5'd2 : (ny_cfg_reg > 5'(tdi_pkg::MaxYPoints))
              ? 5'(tdi_pkg::MaxYPoints) : ny_cfg_reg;

    assign x_we = state_reg == S_WRITE && cmd_reg == tdi_pkg::CMD_WRITE_X;
    assign y_we = state_reg == S_WRITE && cmd_reg == tdi_pkg::CMD_WRITE_Y;
    assign z_we = state_reg == S_WRITE && cmd_reg == tdi_pkg::CMD_WRITE_Z;

    // read address mux for search and table fetch
    always_comb
    begin
        xr_addr = xi_reg[tdi_pkg::XIdxW-1:0];
        yr_addr = yi_reg[tdi_pkg::YIdxW-1:0];
        zr_addr = {xl_reg, yl_reg};
        if (state_reg == S_RD || state_reg == S_RD_WAIT)
        begin
            xr_addr = ph_reg[0] ? xh_reg : xl_reg;
            yr_addr = ph_reg[0] ? yh_reg : yl_reg;
            unique case (ph_reg)
                2'd0: zr_addr = {xl_reg, yl_reg};
                2'd1: zr_addr = {xl_reg, yh_reg};
                2'd2: zr_addr = {xh_reg, yl_reg};
                2'd3: zr_addr = {xh_reg, yh_reg};
                default: zr_addr = '0;
            endcase
        end
    end

    tdi_ram #(.Width(32), .Depth(tdi_pkg::MaxXPoints)) u_xram (
        .clk(clk), .we(x_we), .waddr(row_reg), .wdata(wv_reg),
        .raddr(xr_addr), .rdata(xr_data));
    tdi_ram #(.Width(32), .Depth(tdi_pkg::MaxYPoints)) u_yram (
        .clk(clk), .we(y_we), .waddr(col_reg), .wdata(wv_reg),
        .raddr(yr_addr), .rdata(yr_data));
    tdi_ram #(.Width(32), .Depth(tdi_pkg::MaxXPoints * tdi_pkg::MaxYPoints)) u_zram (
        .clk(clk), .we(z_we), .waddr({row_reg, col_reg}), .wdata(wv_reg),
        .raddr(zr_addr), .rdata(zr_data));

    // step operand select
    always_comb
    begin
        unique case (ph_reg)
            2'd0: args = '{a: ya_reg, q: qy_reg, b: yb_reg, va: z0_reg, vb: z1_reg};
            2'd1: args = '{a: ya_reg, q: qy_reg, b: yb_reg, va: z2_reg, vb: z3_reg};
            default: args = '{a: xa_reg, q: qx_reg, b: xb_reg, va: lo_reg, vb: hi_reg};
        endcase
    end

    tdi_interp_unit u_step (
        .clk(clk), .rst_n(rst_n), .start(start_reg), .args(args),
        .done(sdone), .res(sres));

    assign cfg_ready = 1'b1;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            nx_cfg_reg <= 5'd16;
            ny_cfg_reg <= 5'd16;
            start_reg  <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (cfg_valid)
            begin
                if (cfg_index == tdi_pkg::CFG_X_POINTS) nx_cfg_reg <= cfg_data;
                else ny_cfg_reg <= cfg_data;
            end
            if (ov_reg && m_axis_tready) ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && !ov_reg)
                    begin
                        cmd_reg <= s_axis_tdata[1:0];
                        row_reg <= s_axis_tdata[5:2];
                        col_reg <= s_axis_tdata[9:6];
                        wv_reg  <= s_axis_tdata[41:10];
                        qx_reg  <= s_axis_tdata[73:42];
                        qy_reg  <= s_axis_tdata[105:74];
                        xi_reg  <= '0;
                        yi_reg  <= '0;
                        zs_reg  <= 1'b0;
                        sat_reg <= 1'b0;
                        state_reg <= (s_axis_tdata[1:0] == tdi_pkg::CMD_LOOKUP)
                                   ? S_SX : S_WRITE;
                    end
                end
                S_WRITE: state_reg <= S_IDLE;
                S_SX: state_reg <= S_SX_CHK;
                S_SX_CHK:
                begin
                    // first breakpoint not below query
                    if ($signed(xr_data) >= qx_reg || xi_reg == nx - 5'd1)
                    begin
                        if ($signed(xr_data) < qx_reg || xi_reg == '0)
                        begin
                            xh_reg <= (xi_reg == '0) ? 4'd1 : xi_reg[3:0];
                            xl_reg <= (xi_reg == '0) ? 4'd0 : 4'(xi_reg - 5'd1);
                        end
                        else
                        begin
                            xh_reg <= xi_reg[3:0];
                            xl_reg <= 4'(xi_reg - 5'd1);
                        end
                        state_reg <= S_SY;
                    end
                    else
                    begin
                        xi_reg <= xi_reg + 5'd1;
                        state_reg <= S_SX;
                    end
                end
                S_SY: state_reg <= S_SY_CHK;
                S_SY_CHK:
                begin
                    if ($signed(yr_data) >= qy_reg || yi_reg == ny - 5'd1)
                    begin
                        yh_reg <= (yi_reg == '0) ? 4'd1 : yi_reg[3:0];
                        yl_reg <= (yi_reg == '0) ? 4'd0 : 4'(yi_reg - 5'd1);
                        ph_reg <= 2'd0;
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        yi_reg <= yi_reg + 5'd1;
                        state_reg <= S_SY;
                    end
                end
                S_RD: state_reg <= S_RD_WAIT;
                S_RD_WAIT:
                begin
                    // gather breakpoints and corners
                    unique case (ph_reg)
                        2'd0: begin z0_reg <= zr_data; xa_reg <= xr_data; ya_reg <= yr_data; end
                        2'd1: begin z1_reg <= zr_data; xb_reg <= xr_data; yb_reg <= yr_data; end
                        2'd2: z2_reg <= zr_data;
                        2'd3: z3_reg <= zr_data;
                        default: ;
                    endcase
                    ph_reg <= ph_reg + 2'd1;
                    if (ph_reg == 2'd3)
                    begin
                        state_reg <= S_STEP;
                    end
                    else
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_STEP:
                begin
                    start_reg <= 1'b1;
                    state_reg <= S_STEP_WAIT;
                end
                S_STEP_WAIT:
                begin
                    if (sdone)
                    begin
                        zs_reg  <= zs_reg | sres.zero_span;
                        sat_reg <= sat_reg | sres.saturated;
                        unique case (ph_reg)
                            2'd0: lo_reg <= sres.value;
                            2'd1: hi_reg <= sres.value;
                            default: ;
                        endcase
                        if (ph_reg == 2'd2)
                        begin
                            od_reg <= {6'd0, sat_reg | sres.saturated,
                                       zs_reg | sres.zero_span, sres.value};
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            ph_reg <= ph_reg + 2'd1;
                            state_reg <= S_STEP;
                        end
                    end
                end
                S_OUT:
                begin
                    ov_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = state_reg == S_IDLE && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !s_axis_tready) else $error("ready while busy");
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STEP |-> xh_reg == xl_reg + 4'd1 && yh_reg == yl_reg + 4'd1)
        else $error("bracket pair broken");
endmodule

/* tb/two_d_table_interpolation_core_tb.sv */
// testbench for the 2d table interpolation core: directed table, random stream, predictor check
`timescale 1ns / 100ps

module two_d_table_interpolation_core_tb;
    typedef struct {
        tdi_pkg::cmd_t      cmd;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] wval;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
    } map_item_t;

    typedef struct {
        logic signed [31:0] value;
        bit                 zero_span;
        bit                 saturated;
    } map_result_t;

    typedef struct {
        map_item_t   item;
        bit          typed;
        map_result_t result;
    } directed_row_t;

    localparam int Pause = 300;
    localparam int HoldCycles = 2000;
    localparam int RandomPerPhase = 180;
    localparam int NumPhases = 6;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_index = tdi_pkg::CFG_X_POINTS;
    logic [4:0]   cfg_data = 5'd16;

    // predictor copy of the map and the point counts
    logic signed [31:0] x_bp [tdi_pkg::MaxXPoints];
    logic signed [31:0] y_bp [tdi_pkg::MaxYPoints];
    logic signed [31:0] z_map [tdi_pkg::MaxXPoints][tdi_pkg::MaxYPoints];
    logic [4:0]         x_count = 5'd16;
    logic [4:0]         y_count = 5'd16;

    map_result_t pending_results[$];
    int  errors = 0;
    int  lookups_checked = 0;
    int  writes_sent = 0;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;

    directed_row_t directed [$];

    always #5 clk = ~clk;

    two_d_table_interpolation_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // one linear step: va + (q - a) * (vb - va) / (b - a), saturated
    function automatic logic signed [31:0] lerp_step(
        input logic signed [31:0] a, q, b, va, vb,
        inout bit zs, inout bit sat);
        longint dq, dv, dd, r;
        longint unsigned mq, mv, md, quo;
        bit neg;
        dq = longint'(q) - longint'(a);
        dv = longint'(vb) - longint'(va);
        dd = longint'(b) - longint'(a);
        if (dd == 0)
        begin
            zs = 1'b1;
            return va;
        end
        mq = (dq < 0) ? -dq : dq;
        mv = (dv < 0) ? -dv : dv;
        md = (dd < 0) ? -dd : dd;
        neg = ((dq < 0) != (dv < 0)) != (dd < 0);
        quo = (mq * mv) / md;
        if (quo > 64'h1_0000_0000)
        begin
            sat = 1'b1;
            return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        r = neg ? longint'(va) - longint'(quo) : longint'(va) + longint'(quo);
        if (r > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7fff_ffff;
        end
        if (r < -64'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return r[31:0];
    endfunction

    // first breakpoint not below the query, with its predecessor
    function automatic void find_pair(input logic signed [31:0] q,
        input logic signed [31:0] bp [16], input logic [4:0] count,
        output int lo, output int hi);
        int n;
        n = (count < 2) ? 2 : (count > 16) ? 16 : count;
        for (int i = 0; i < n; i++)
        begin
            if (bp[i] >= q)
            begin
                lo = (i == 0) ? 0 : i - 1;
                hi = (i == 0) ? 1 : i;
                return;
            end
        end
        lo = n - 2;
        hi = n - 1;
    endfunction

    // apply one accepted item to the map copy, return expectation for lookups
    function automatic bit predict_map(input map_item_t it, output map_result_t res);
        int xl, xh, yl, yh;
        logic signed [31:0] lo_z, hi_z;
        bit zs, sat;
        zs = 1'b0;
        sat = 1'b0;
        res = '{default: 0};
        case (it.cmd)
            tdi_pkg::CMD_WRITE_X: x_bp[it.row] = it.wval;
            tdi_pkg::CMD_WRITE_Y: y_bp[it.col] = it.wval;
            tdi_pkg::CMD_WRITE_Z: z_map[it.row][it.col] = it.wval;
            default:
            begin
                find_pair(it.qx, x_bp, x_count, xl, xh);
                find_pair(it.qy, y_bp, y_count, yl, yh);
                lo_z = lerp_step(y_bp[yl], it.qy, y_bp[yh], z_map[xl][yl], z_map[xl][yh],
                    zs, sat);
                hi_z = lerp_step(y_bp[yl], it.qy, y_bp[yh], z_map[xh][yl], z_map[xh][yh],
                    zs, sat);
                res.value = lerp_step(x_bp[xl], it.qx, x_bp[xh], lo_z, hi_z, zs, sat);
                res.zero_span = zs;
                res.saturated = sat;
            end
        endcase
        return it.cmd == tdi_pkg::CMD_LOOKUP;
    endfunction

    // offer one item, random idle before it unless calm
    task automatic send_item(input map_item_t it, input bit typed, input map_result_t typed_res);
        map_result_t res;
        if (!calm && $urandom_range(0, 99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, it.qy, it.qx, it.wval, it.col, it.row, it.cmd};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (predict_map(it, res))
            pending_results.push_back(typed ? typed_res : res);
        else
            writes_sent++;
    endtask

    task automatic send_plain(input map_item_t it);
        send_item(it, 1'b0, '{default: 0});
    endtask

    // offer one register write; the caller drops valid after the last one
    task automatic write_count(input logic idx, input logic [4:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == tdi_pkg::CFG_X_POINTS)
            x_count = value;
        else
            y_count = value;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (Pause) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord(input int count);
        if ($urandom_range(0, 99) < 75)
            return $signed($urandom_range(0, (count + 4) << 16)) - (2 << 16);
        return $urandom;
    endfunction

    function automatic map_item_t rand_item();
        map_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        it.row = 4'($urandom);
        it.col = 4'($urandom);
        it.qx = $urandom;
        it.qy = $urandom;
        it.wval = $urandom;
        if (pick < 55)
        begin
            it.cmd = tdi_pkg::CMD_LOOKUP;
            it.qx = rand_coord(16);
            it.qy = rand_coord(16);
        end
        else if (pick < 72)
        begin
            it.cmd = tdi_pkg::CMD_WRITE_Z;
            if ($urandom_range(0, 99) < 80)
                it.wval = $signed($urandom_range(0, 128 << 16)) - (64 << 16);
        end
        else
        begin
            it.cmd = (pick < 86) ? tdi_pkg::CMD_WRITE_X : tdi_pkg::CMD_WRITE_Y;
            // mostly keep the axis ascending, sometimes any value
            if ($urandom_range(0, 99) < 85)
                it.wval = ((it.cmd == tdi_pkg::CMD_WRITE_X ? it.row : it.col) << 16)
                    + $urandom_range(0, 16'h7fff);
        end
        return it;
    endfunction

    function automatic map_item_t mk(input tdi_pkg::cmd_t c, input int r, input int k,
        input logic signed [31:0] w, input logic signed [31:0] x, input logic signed [31:0] y);
        map_item_t it;
        it.cmd = c;
        it.row = 4'(r);
        it.col = 4'(k);
        it.wval = w;
        it.qx = x;
        it.qy = y;
        return it;
    endfunction

    // result side: check accepted items, random and long stalls
    always @(posedge clk)
    begin
        map_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                lookups_checked++;
                if ($signed(m_axis_tdata[31:0]) !== want.value)
                begin
                    $error("interpolated expected %h actual %h", want.value, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[32] !== want.zero_span)
                begin
                    $error("zero_span expected %0d actual %0d", want.zero_span,
                        m_axis_tdata[32]);
                    errors++;
                end
                if (m_axis_tdata[33] !== want.saturated)
                begin
                    $error("saturated expected %0d actual %0d", want.saturated,
                        m_axis_tdata[33]);
                    errors++;
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HoldCycles;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= calm || $urandom_range(0, 99) >= 12;
    end

    // run limit
    initial
    begin
        #50_000_000;
        $display("two_d_table_interpolation_core: mismatch");
        $finish;
    end

    initial
    begin
        logic [4:0] x_set [NumPhases];
        logic [4:0] y_set [NumPhases];
        map_result_t none;
        none = '{default: 0};
        x_set = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd5, 5'd17};
        y_set = '{5'd16, 5'd2, 5'd1, 5'd17, 5'd9, 5'd3};
        for (int i = 0; i < 16; i++)
        begin
            x_bp[i] = 0;
            y_bp[i] = 0;
            for (int j = 0; j < 16; j++)
                z_map[i][j] = 0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load a linear map: axes at integers, z = 16 * row + column
        calm = 1'b1;
        for (int i = 0; i < 16; i++)
        begin
            send_plain(mk(tdi_pkg::CMD_WRITE_X, i, 15 - i, i << 16, 0, 0));
            send_plain(mk(tdi_pkg::CMD_WRITE_Y, 15 - i, i, i << 16, 0, 0));
        end
        for (int i = 0; i < 16; i++)
            for (int j = 0; j < 16; j++)
                send_plain(mk(tdi_pkg::CMD_WRITE_Z, i, j, (16 * i + j) << 16, 0, 0));
        calm = 1'b0;

        // directed table
        directed.push_back('{mk(tdi_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0), 1, '{0, 0, 0}});
        directed.push_back('{mk(tdi_pkg::CMD_LOOKUP, 15, 15, -1, 1 << 16, 2 << 16), 1,
            '{18 << 16, 0, 0}});
        directed.push_back('{mk(tdi_pkg::CMD_LOOKUP, 0, 0, 0, 15 << 16, 15 << 16), 1,
            '{255 << 16, 0, 0}});
        directed.push_back('{mk(tdi_pkg::CMD_LOOKUP, 0, 0, 0, 32'h8000, 32'h8000), 1,
            '{32'h0008_8000, 0, 0}});
        directed.push_back('{mk(tdi_pkg::CMD_LOOKUP, 0, 0, 0, 32'sh7fff_ffff, 0), 1,
            '{32'sh7fff_ffff, 0, 1}});
        directed.push_back('{mk(tdi_pkg::CMD_LOOKUP, 0, 0, 0, 32'sh8000_0000, 0), 1,
            '{32'sh8000_0000, 0, 1}});
        directed.push_back('{mk(tdi_pkg::CMD_LOOKUP, 0, 0, 0, 0, 32'sh7fff_ffff), 0, none});
        directed.push_back('{mk(tdi_pkg::CMD_LOOKUP, 0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000),
            0, none});
        // equal x breakpoints give the lower row value
        directed.push_back('{mk(tdi_pkg::CMD_WRITE_X, 1, 0, 0, 0, 0), 0, none});
        directed.push_back('{mk(tdi_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0), 1, '{0, 1, 0}});
        directed.push_back('{mk(tdi_pkg::CMD_WRITE_X, 1, 0, 1 << 16, 0, 0), 0, none});
        // z extremes
        directed.push_back('{mk(tdi_pkg::CMD_WRITE_Z, 15, 15, 32'sh7fff_ffff, 0, 0), 0, none});
        directed.push_back('{mk(tdi_pkg::CMD_LOOKUP, 0, 0, 0, 15 << 16, 15 << 16), 1,
            '{32'sh7fff_ffff, 0, 0}});
        directed.push_back('{mk(tdi_pkg::CMD_WRITE_Z, 15, 15, 32'sh8000_0000, 0, 0), 0, none});
        directed.push_back('{mk(tdi_pkg::CMD_LOOKUP, 0, 0, 0, 20 << 16, 20 << 16), 0, none});
        directed.push_back('{mk(tdi_pkg::CMD_WRITE_Z, 15, 15, 255 << 16, 0, 0), 0, none});
        // descending y axis at the top end
        directed.push_back('{mk(tdi_pkg::CMD_WRITE_Y, 0, 15, 32'sh8000_0000, 0, 0), 0, none});
        directed.push_back('{mk(tdi_pkg::CMD_LOOKUP, 0, 0, 0, 3 << 16, 15 << 16), 0, none});
        directed.push_back('{mk(tdi_pkg::CMD_LOOKUP, 0, 0, 0, -1, 32'sh7fff_ffff), 0, none});
        directed.push_back('{mk(tdi_pkg::CMD_WRITE_Y, 0, 15, 15 << 16, 0, 0), 0, none});
        foreach (directed[i])
            send_item(directed[i].item, directed[i].typed, directed[i].result);

        // random phases under different point counts
        for (int p = 0; p < NumPhases; p++)
        begin
            wait_idle();
            write_count(tdi_pkg::CFG_X_POINTS, x_set[p]);
            write_count(tdi_pkg::CFG_Y_POINTS, y_set[p]);
            cfg_valid <= 1'b0;
            calm = (p == 4);
            hold_req = (p == 2);
            for (int n = 0; n < RandomPerPhase; n++)
                send_plain(rand_item());
        end
        calm = 1'b0;
        wait_idle();

        $display("covered %0d lookups and %0d table writes over %0d point-count settings",
            lookups_checked, writes_sent, NumPhases);
        if (errors == 0)
            $display("two_d_table_interpolation_core: match");
        else
            $display("two_d_table_interpolation_core: mismatch");
        $finish;
    end
endmodule
